// File: sv/sarc_pkg.sv
// Package for the comparator reference calibrator: opcodes, register indexes and beat layouts.
package sarc_pkg;

  // Input beat opcodes
  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_TICK   = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_PIN    = 3'd4
  } op_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL_LENGTH = 1'd0,
    REG_SETTLING_TIME   = 1'd1
  } cfg_reg_t;

  localparam int TIME_W     = 32;
  localparam int OUT_CODE_W = 8;

  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd1000;
  localparam logic [TIME_W-1:0] SETTLING_RESET = 32'd10;

  // Packed widths of the stream data buses
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

endpackage

// File: sv/sar_reference_calibrator.sv
// Successive-approximation calibrator for an 8-bit comparator reference code.
//
// Usage: configuration is written on cfg_we / cfg_index / cfg_wdata while the block
// is idle (index 0 interval_length, index 1 settling_time). Each input beat on the
// in_ stream carries an opcode (start, update tick, pause, resume, pin change), a
// 32-bit time stamp and the comparator level. Every input beat produces exactly one
// result beat on the out_ stream with the current reference code and status flags.
//
// Each beat passes through the input register, then the update logic (a time difference,
// a 32-bit accumulate and a 33-bit compare) feeding the state and the result register.
// Throughput is one beat per cycle; the pipeline holds both stages while a result
// waits with out_tready low, and in_tready stays high while the input register is
// empty, so one beat is taken even during a stall.
//
// Reset (rst_n low, synchronous) empties both stages, loads the register defaults
// (interval 1000, settling 10), sets the code and trial bit to the top bit and marks
// the calibration finished until a start beat arrives.
module sar_reference_calibrator #(
  parameter int CODE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: opcode[2:0], now[34:3], comparator_level[35], zero fill [39:36]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sarc_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: reference_code[7:0], reference_written[8], finished[9], paused[10],
  //            sampling_enabled[11], zero fill [15:12]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sarc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [sarc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sarc_pkg::TIME_W-1:0]         cfg_wdata
);

  localparam int TW = sarc_pkg::TIME_W;
  localparam logic [CODE_BITS-1:0] TOP_BIT = {1'b1, {(CODE_BITS-1){1'b0}}};

  // Configuration registers
  logic [TW-1:0] interval_r;
  logic [TW-1:0] settling_r;

  // Input stage
  logic          in_valid_r;
  sarc_pkg::op_t in_op_r;
  logic [TW-1:0] in_now_r;
  logic          in_lvl_r;

  // Calibration state
  logic [CODE_BITS-1:0] ref_code_r, ref_code_nxt;
  logic [CODE_BITS-1:0] mask_r, mask_nxt;
  logic [TW-1:0] high_r, high_nxt;
  logic [TW-1:0] low_r, low_nxt;
  logic [TW-1:0] chg_stamp_r, chg_stamp_nxt;
  logic [TW-1:0] ref_stamp_r, ref_stamp_nxt;
  logic lvl_valid_r, lvl_valid_nxt;
  logic lvl_value_r, lvl_value_nxt;
  logic waiting_r, waiting_nxt;
  logic paused_r, paused_nxt;
  logic finished_r, finished_nxt;
  logic pin_on_r, pin_on_nxt;
  logic written_nxt;

  // Result stage
  logic                  out_valid_r;
  logic [sarc_pkg::OUT_DATA_W-1:0] out_data_r;

  // Tick datapath
  logic [TW-1:0]        delta;
  logic [TW-1:0]        high_acc, low_acc;
  logic [TW:0]          total;
  logic [CODE_BITS-1:0] cand;
  logic                 settle_done;

  logic advance;
  logic work;

  assign advance   = !out_valid_r || out_tready;
  assign work      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= sarc_pkg::INTERVAL_RESET;
      settling_r <= sarc_pkg::SETTLING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sarc_pkg::REG_INTERVAL_LENGTH: interval_r <= cfg_wdata;
        sarc_pkg::REG_SETTLING_TIME:   settling_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: take a beat when empty or when it drains this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r  <= sarc_pkg::op_t'(in_tdata[2:0]);
      in_now_r <= in_tdata[34:3];
      in_lvl_r <= in_tdata[35];
    end
  end

  // Next state for the beat in the input register
  always_comb begin
    ref_code_nxt  = ref_code_r;
    mask_nxt      = mask_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    chg_stamp_nxt = chg_stamp_r;
    ref_stamp_nxt = ref_stamp_r;
    lvl_valid_nxt = lvl_valid_r;
    lvl_value_nxt = lvl_value_r;
    waiting_nxt   = waiting_r;
    paused_nxt    = paused_r;
    finished_nxt  = finished_r;
    pin_on_nxt    = pin_on_r;
    written_nxt   = 1'b0;
    settle_done   = waiting_r && (settling_r < (in_now_r - ref_stamp_r));
    delta         = '0;
    high_acc      = high_r;
    low_acc       = low_r;
    total         = '0;
    cand          = ref_code_r;

    case (in_op_r)
      sarc_pkg::OP_START: begin
        chg_stamp_nxt = in_now_r;
        lvl_valid_nxt = 1'b0;
        lvl_value_nxt = 1'b0;
        high_nxt      = '0;
        low_nxt       = '0;
        finished_nxt  = 1'b0;
        mask_nxt      = TOP_BIT;
        pin_on_nxt    = 1'b0;
        waiting_nxt   = 1'b1;
        ref_code_nxt  = TOP_BIT;
        ref_stamp_nxt = in_now_r;
        written_nxt   = 1'b1;
      end
      sarc_pkg::OP_TICK: begin
        if (!finished_r) begin
          // End the settling wait and sample the level
          if (settle_done) begin
            waiting_nxt   = 1'b0;
            chg_stamp_nxt = in_now_r;
            lvl_value_nxt = in_lvl_r;
            lvl_valid_nxt = 1'b1;
            pin_on_nxt    = 1'b1;
          end
          if (!paused_r && !waiting_nxt) begin
            // Accumulate time at the current level
            if (lvl_valid_nxt) begin
              delta = in_now_r - chg_stamp_nxt;
              if (lvl_value_nxt) high_acc = high_r + delta;
              else               low_acc  = low_r + delta;
              chg_stamp_nxt = in_now_r;
            end
            high_nxt = high_acc;
            low_nxt  = low_acc;
            total    = {1'b0, high_acc} + {1'b0, low_acc};
            // Decide the trial bit once the accumulated time exceeds the interval
            if (total > {1'b0, interval_r}) begin
              if (high_acc > low_acc) cand = ref_code_r & ~mask_r;
              if (mask_r[CODE_BITS-1:1] == '0) begin
                finished_nxt = 1'b1;
                pin_on_nxt   = 1'b0;
              end else begin
                mask_nxt = mask_r >> 1;
                cand     = cand | (mask_r >> 1);
                high_nxt = '0;
                low_nxt  = '0;
              end
              if (cand != ref_code_r) begin
                pin_on_nxt    = 1'b0;
                waiting_nxt   = 1'b1;
                ref_code_nxt  = cand;
                ref_stamp_nxt = in_now_r;
                written_nxt   = 1'b1;
              end
            end
          end
        end
      end
      sarc_pkg::OP_PAUSE: begin
        paused_nxt = 1'b1;
        pin_on_nxt = 1'b0;
      end
      sarc_pkg::OP_RESUME: begin
        paused_nxt    = 1'b0;
        chg_stamp_nxt = in_now_r;
        lvl_value_nxt = in_lvl_r;
        lvl_valid_nxt = 1'b1;
        pin_on_nxt    = 1'b1;
      end
      sarc_pkg::OP_PIN: begin
        if (pin_on_r) begin
          lvl_value_nxt = in_lvl_r;
          lvl_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State update on each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_code_r  <= TOP_BIT;
      mask_r      <= TOP_BIT;
      high_r      <= '0;
      low_r       <= '0;
      chg_stamp_r <= '0;
      ref_stamp_r <= '0;
      lvl_valid_r <= 1'b0;
      lvl_value_r <= 1'b0;
      waiting_r   <= 1'b0;
      paused_r    <= 1'b0;
      finished_r  <= 1'b1;
      pin_on_r    <= 1'b0;
    end else if (work) begin
      ref_code_r  <= ref_code_nxt;
      mask_r      <= mask_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      chg_stamp_r <= chg_stamp_nxt;
      ref_stamp_r <= ref_stamp_nxt;
      lvl_valid_r <= lvl_valid_nxt;
      lvl_value_r <= lvl_value_nxt;
      waiting_r   <= waiting_nxt;
      paused_r    <= paused_nxt;
      finished_r  <= finished_nxt;
      pin_on_r    <= pin_on_nxt;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_data_r <= {4'b0000, pin_on_nxt, paused_nxt, finished_nxt, written_nxt,
                     sarc_pkg::OUT_CODE_W'(ref_code_nxt)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Trial mask always holds a single bit
  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(mask_r))
    else $error("trial mask is not one-hot");

  // Code bits below the trial bit stay clear
  a_low_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ref_code_r & (mask_r - 1'b1)) == '0)
    else $error("code has bits set below the trial bit");

  // A code write arms settling and stops pin sampling
  a_write_settles: assert property (@(posedge clk) disable iff (!rst_n)
    (work && written_nxt) |=> (waiting_r && !pin_on_r))
    else $error("code write did not arm the settling wait");

  // Input stage only refuses a beat while it holds one
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r))
    else $error("input refused while pipeline had room");

endmodule
